// ===== rtl/core/lpfd_pkg.sv =====
`default_nettype none

package lpfd_pkg;

  localparam int unsigned HDR_BYTES   = 12;
  localparam int unsigned STORE_DEPTH = HDR_BYTES - 1;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned LEN_W       = 25;
  localparam int unsigned CFG_W       = 25;

  localparam logic [7:0]       VERSION_RESET = 8'd1;
  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 25'h100_0000;

  typedef enum logic [0:0] {
    REG_EXPECTED_VERSION = 1'b0,
    REG_MAX_PAYLOAD      = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  localparam logic CAUSE_VERSION = 1'b0;
  localparam logic CAUSE_LENGTH  = 1'b1;

  typedef struct packed {
    logic             last;
    logic             error_cause;
    logic [7:0]       payload_byte;
    logic [LEN_W-1:0] payload_length;
    logic [31:0]      stream_id;
    logic [15:0]      frame_flags;
    logic [7:0]       frame_type;
    kind_t            kind;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/lpfd_parse.sv =====
`default_nettype none

module lpfd_parse import lpfd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_take,
  input  wire logic [7:0]       data_byte,
  input  wire logic             resync,
  input  wire logic [7:0]       expected_version,
  input  wire logic [LEN_W-1:0] max_payload,
  output logic                  res_valid,
  output result_t               res
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_ERROR   = 2'd2
  } phase_t;

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] header_count, header_count_next;
  logic [LEN_W-1:0] payload_left, payload_left_next;
  logic [7:0]       header_store [STORE_DEPTH];
  logic             store_wr;

  logic [31:0]      hdr_len;
  logic             ver_bad, len_bad;
  logic [LEN_W-1:0] left_dec;

  // header_store[STORE_DEPTH-1] holds the oldest (version) byte
  assign hdr_len  = {header_store[2], header_store[1], header_store[0], data_byte};
  assign ver_bad  = header_store[STORE_DEPTH-1] != expected_version;
  assign len_bad  = hdr_len > {{(32-LEN_W){1'b0}}, max_payload};
  assign left_dec = (payload_left != '0) ? payload_left - LEN_W'(1) : payload_left;

  always_comb begin
    phase_next        = phase;
    header_count_next = header_count;
    payload_left_next = payload_left;
    store_wr          = 1'b0;
    res_valid         = 1'b0;
    res               = '0;
    res.kind          = KIND_HEADER;
    if (resync) begin
      phase_next        = PH_HEADER;
      header_count_next = '0;
      payload_left_next = '0;
    end else begin
      unique case (phase)
        PH_ERROR: begin
        end
        PH_PAYLOAD: begin
          payload_left_next = left_dec;
          res_valid         = 1'b1;
          res.kind          = KIND_PAYLOAD;
          res.payload_byte  = data_byte;
          if (left_dec == '0) begin
            res.last   = 1'b1;
            phase_next = PH_HEADER;
          end
        end
        default: begin
          phase_next = PH_HEADER;
          if (header_count < CNT_W'(STORE_DEPTH)) begin
            store_wr          = 1'b1;
            header_count_next = header_count + CNT_W'(1);
          end else begin
            header_count_next = '0;
            res_valid         = 1'b1;
            if (ver_bad || len_bad) begin
              res.kind        = KIND_ERROR;
              res.error_cause = ver_bad ? CAUSE_VERSION : CAUSE_LENGTH;
              res.last        = 1'b1;
              phase_next      = PH_ERROR;
            end else begin
              res.frame_type     = header_store[STORE_DEPTH-2];
              res.frame_flags    = {header_store[STORE_DEPTH-3], header_store[STORE_DEPTH-4]};
              res.stream_id      = {header_store[6], header_store[5],
                                    header_store[4], header_store[3]};
              res.payload_length = hdr_len[LEN_W-1:0];
              if (hdr_len == '0) begin
                res.last = 1'b1;
              end else begin
                payload_left_next = hdr_len[LEN_W-1:0];
                phase_next        = PH_PAYLOAD;
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_count <= '0;
      payload_left <= '0;
    end else if (in_take) begin
      phase        <= phase_next;
      header_count <= header_count_next;
      payload_left <= payload_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && store_wr) begin
      header_store[0] <= data_byte;
      for (int i = 1; i < STORE_DEPTH; i++) begin
        header_store[i] <= header_store[i-1];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lpfd_skid.sv =====
`default_nettype none

module lpfd_skid import lpfd_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         full,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop  = out_valid && out_ready;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/length_prefixed_frame_deframer_top.sv =====
`default_nettype none

// Length-prefixed frame deframer. Takes one stream byte per transfer and
// collects a 12-byte big-endian header (version, type, flags, stream id,
// length). A good header yields one header result, then one result per
// payload byte, with tlast on the final one (on the header itself for an
// empty frame). A bad version or a length above max_payload yields one
// error result with tlast, after which bytes are dropped until a transfer
// with resync set. One byte is accepted every cycle while s_tready is high;
// version and length are checked on the twelfth byte, and a two-entry
// output buffer lowers s_tready only once both of its entries are full.

module length_prefixed_frame_deframer_top import lpfd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [0:0]       cfg_addr,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [7:0]       s_tdata,   // data_byte
  input  wire logic             s_tuser,   // resync
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [95:0]           m_tdata,   // frame_type, frame_flags, stream_id,
                                           // payload_length, payload_byte,
                                           // error_cause, zero fill
  output logic [1:0]            m_tuser,   // kind
  output logic                  m_tlast
);

  logic [7:0]       expected_version;
  logic [LEN_W-1:0] max_payload;
  logic             in_take;
  logic             res_valid;
  result_t          res;
  logic             skid_full;
  result_t          out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= VERSION_RESET;
      max_payload      <= MAX_PAYLOAD_RESET;
    end else if (cfg_wr_en) begin
      unique case (reg_index_t'(cfg_addr))
        REG_EXPECTED_VERSION: expected_version <= cfg_wdata[7:0];
        REG_MAX_PAYLOAD:      max_payload      <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_tready = !skid_full;
  assign in_take  = s_tvalid && s_tready;

  lpfd_parse u_parse (
    .clk              (clk),
    .rst              (rst),
    .in_take          (in_take),
    .data_byte        (s_tdata),
    .resync           (s_tuser),
    .expected_version (expected_version),
    .max_payload      (max_payload),
    .res_valid        (res_valid),
    .res              (res)
  );

  lpfd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (in_take && res_valid),
    .push_data (res),
    .full      (skid_full),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {6'b0, out_res.error_cause, out_res.payload_byte, out_res.payload_length,
                    out_res.stream_id, out_res.frame_flags, out_res.frame_type};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last;

endmodule

`default_nettype wire
